FILE: hw/rtl/pbis_pkg.sv
package pbis_pkg;

    localparam int STORE_DEPTH  = 8;
    localparam int IDX_W        = $clog2(STORE_DEPTH);
    localparam int CNT_W        = $clog2(STORE_DEPTH + 1);
    localparam int TIME_W       = 64;
    localparam int TOL_W        = 16;
    localparam int OUT_IDX_W    = 3;
    localparam int CHOSEN_W     = 2;

    localparam logic [CHOSEN_W-1:0] CHOSEN_MIN = 2'd0;
    localparam logic [CHOSEN_W-1:0] CHOSEN_A   = 2'd1;
    localparam logic [CHOSEN_W-1:0] CHOSEN_B   = 2'd2;

    typedef struct packed {
        logic [TOL_W-1:0] two;
        logic [TOL_W-1:0] first_pair;
        logic [TOL_W-1:0] other_pair;
    } t_tol;

    // The first member lands in the highest bits, so ok sits at bit zero.
    typedef struct packed {
        logic [CHOSEN_W-1:0]  chosen;
        logic [OUT_IDX_W-1:0] b_index;
        logic [TIME_W-1:0]    b_right;
        logic [TIME_W-1:0]    b_left;
        logic                 b_valid;
        logic [OUT_IDX_W-1:0] a_index;
        logic [TIME_W-1:0]    a_right;
        logic [TIME_W-1:0]    a_left;
        logic                 a_valid;
        logic [TIME_W-1:0]    t_min;
        logic [OUT_IDX_W-1:0] min_index;
        logic                 ok;
    } t_result;

endpackage

FILE: hw/rtl/pbis_engine.sv
module pbis_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_cmd,
    input  logic [pbis_pkg::TIME_W-1:0]   i_core_time,
    input  logic [pbis_pkg::TIME_W-1:0]   i_total_time,
    input  logic                          i_direction,
    input  logic                          i_last,
    input  logic [pbis_pkg::TIME_W-1:0]   i_query_time,
    input  pbis_pkg::t_tol                i_tol,
    input  logic                          i_out_free,
    output logic                          o_push,
    output pbis_pkg::t_result             o_result
);
    import pbis_pkg::*;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;
    localparam int   POS_W     = CNT_W;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DISPATCH, ST_F0, ST_F1, ST_F2, ST_ABS, ST_M0, ST_M1,
        ST_MLOOP, ST_SMIN, ST_Q0, ST_Q1, ST_EMIT
    } t_state;

    typedef enum logic [1:0] {JOB_PAIR, JOB_DIR, JOB_SPAN_A, JOB_SPAN_B} t_job;

    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] left;
        logic [TIME_W-1:0] right;
        logic [IDX_W-1:0]  idx;
    } t_span;

    function automatic logic [POS_W-1:0] mod_add(input logic [POS_W-1:0] b,
                                                  input logic [2:0]       off,
                                                  input logic [POS_W-1:0] m);
        logic [POS_W:0] s;
        s = {1'b0, b} + (POS_W+1)'(off);
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[POS_W-1:0];
    endfunction

    // With the merged four-profile set, position zero keeps profile zero and
    // the others skip over the dropped profile one.
    function automatic logic [IDX_W-1:0] map_pos(input logic [POS_W-1:0] pos,
                                                  input logic             drop1);
        logic [POS_W-1:0] p;
        p = (drop1 && pos != '0) ? pos + POS_W'(1) : pos;
        return p[IDX_W-1:0];
    endfunction

    logic [TIME_W-1:0] core_mem  [STORE_DEPTH];
    logic [TIME_W-1:0] total_mem [STORE_DEPTH];
    logic              dir_mem   [STORE_DEPTH];

    t_state            r_state;
    t_job              r_job;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_n;
    logic [POS_W-1:0]  r_m;
    logic [POS_W-1:0]  r_i;
    logic [POS_W-1:0]  r_best;
    logic [TIME_W-1:0] r_best_core;
    logic [IDX_W-1:0]  r_fx;
    logic [IDX_W-1:0]  r_fy;
    logic [IDX_W-1:0]  r_bx;
    logic [IDX_W-1:0]  r_by;
    logic [TIME_W-1:0] r_opa;
    logic [TIME_W-1:0] r_diff;
    logic              r_borrow;
    logic              r_dira;
    logic              r_dirb;
    logic [1:0]        r_pc;
    logic              r_two;
    logic              r_drop1;
    logic              r_tie_le;
    logic              r_ge_b;
    logic              r_ok;
    logic [CHOSEN_W-1:0] r_chosen;
    logic [IDX_W-1:0]  r_min_idx;
    logic [TIME_W-1:0] r_min_time;
    t_span             r_a;
    t_span             r_b;

    logic [TIME_W-1:0] r_rd_core;
    logic [TIME_W-1:0] r_rd_total;
    logic              r_rd_dir;

    logic [IDX_W-1:0]  rd_addr;
    logic              mem_wr;
    logic              accept;
    logic [TIME_W-1:0] alu_x;
    logic [TIME_W-1:0] alu_y;
    logic [TIME_W-1:0] alu_diff;
    logic              alu_borrow;
    logic [TOL_W-1:0]  tol_sel;
    logic              abs_lt;
    logic              pair_pass;
    logic              min_upd;
    logic              min_done;
    logic [POS_W-1:0]  best_sel;
    logic [IDX_W-1:0]  e0;
    logic [IDX_W-1:0]  e1;
    logic [IDX_W-1:0]  e2;
    logic [IDX_W-1:0]  e3;
    logic              span_lt;
    t_span             span_new;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign mem_wr     = accept && (i_cmd == CMD_LOAD) && (r_count < CNT_W'(STORE_DEPTH));
    assign o_push     = (r_state == ST_EMIT) && i_out_free;

    // The one shared subtractor: every compare between two times and the absolute
    // difference run through it.
    always_comb begin
        alu_x = r_opa;
        alu_y = '0;
        case (r_state)
            ST_F2: begin
                alu_y = (r_job == JOB_PAIR) ? r_rd_core : r_rd_total;
            end
            ST_ABS: begin
                alu_x = r_borrow ? '0 : r_diff;
                alu_y = r_borrow ? r_diff : '0;
            end
            ST_MLOOP: begin
                alu_x = r_rd_core;
                alu_y = r_best_core;
            end
            ST_Q0: begin
                alu_y = r_b.right;
            end
            ST_Q1: begin
                alu_y = r_a.right;
            end
            default: begin
                alu_y = '0;
            end
        endcase
        {alu_borrow, alu_diff} = {1'b0, alu_x} - {1'b0, alu_y};
    end

    always_comb begin
        if (r_two) begin
            tol_sel = i_tol.two;
        end else if (r_pc == 2'd0) begin
            tol_sel = i_tol.first_pair;
        end else begin
            tol_sel = i_tol.other_pair;
        end
    end

    assign abs_lt    = (alu_diff[TIME_W-1:TOL_W] == '0) && (alu_diff[TOL_W-1:0] < tol_sel);
    assign pair_pass = abs_lt && (r_two || (r_dira != r_dirb));
    assign min_upd   = alu_borrow || (r_tie_le && (alu_diff == '0));
    assign best_sel  = min_upd ? r_i : r_best;
    assign min_done  = (r_i == r_m - POS_W'(1));

    assign e0 = map_pos(mod_add(r_best, 3'd1, r_m), r_drop1);
    assign e1 = map_pos(mod_add(r_best, 3'd2, r_m), r_drop1);
    assign e2 = map_pos(mod_add(r_best, 3'd3, r_m), r_drop1);
    assign e3 = map_pos(mod_add(r_best, 3'd4, r_m), r_drop1);

    assign span_lt        = alu_borrow;
    assign span_new.valid = 1'b1;
    assign span_new.left  = span_lt ? r_opa : r_rd_total;
    assign span_new.right = span_lt ? r_rd_total : r_opa;
    assign span_new.idx   = span_lt ? r_fy : r_fx;

    always_comb begin
        case (r_state)
            ST_F0:    rd_addr = r_fx;
            ST_F1:    rd_addr = r_fy;
            ST_M0:    rd_addr = map_pos('0, r_drop1);
            ST_M1:    rd_addr = (r_m == POS_W'(1)) ? map_pos('0, r_drop1)
                                                   : map_pos(POS_W'(1), r_drop1);
            ST_MLOOP: rd_addr = min_done ? map_pos(best_sel, r_drop1)
                                         : map_pos(r_i + POS_W'(1), r_drop1);
            default:  rd_addr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            core_mem[r_count[IDX_W-1:0]]  <= i_core_time;
            total_mem[r_count[IDX_W-1:0]] <= i_total_time;
            dir_mem[r_count[IDX_W-1:0]]   <= i_direction;
        end
        r_rd_core  <= core_mem[rd_addr];
        r_rd_total <= total_mem[rd_addr];
        r_rd_dir   <= dir_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_count    <= '0;
            r_min_idx  <= '0;
            r_min_time <= '0;
            r_a        <= '0;
            r_b        <= '0;
            r_ok       <= 1'b0;
            r_chosen   <= CHOSEN_MIN;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        if (i_cmd == CMD_QUERY) begin
                            r_opa   <= i_query_time;
                            r_state <= ST_Q0;
                        end else if (i_last) begin
                            r_n     <= (r_count < CNT_W'(STORE_DEPTH)) ?
                                       r_count + CNT_W'(1) : CNT_W'(STORE_DEPTH);
                            r_count <= '0;
                            r_state <= ST_DISPATCH;
                        end else if (r_count < CNT_W'(STORE_DEPTH)) begin
                            r_count <= r_count + CNT_W'(1);
                        end
                    end
                end
                ST_DISPATCH: begin
                    r_drop1  <= 1'b0;
                    r_tie_le <= 1'b0;
                    r_pc     <= 2'd0;
                    r_job    <= JOB_PAIR;
                    r_fx     <= IDX_W'(0);
                    r_fy     <= IDX_W'(1);
                    if (r_n == CNT_W'(2)) begin
                        r_two   <= 1'b1;
                        r_state <= ST_F0;
                    end else if (r_n == CNT_W'(4)) begin
                        r_two   <= 1'b0;
                        r_state <= ST_F0;
                    end else if (r_n[0]) begin
                        r_two   <= 1'b0;
                        r_m     <= r_n;
                        r_state <= ST_M0;
                    end else begin
                        r_ok     <= 1'b0;
                        r_chosen <= CHOSEN_MIN;
                        r_state  <= ST_EMIT;
                    end
                end
                ST_F0: begin
                    r_state <= ST_F1;
                end
                ST_F1: begin
                    r_opa   <= (r_job == JOB_PAIR) ? r_rd_core : r_rd_total;
                    r_dira  <= r_rd_dir;
                    r_state <= ST_F2;
                end
                ST_F2: begin
                    case (r_job)
                        JOB_PAIR: begin
                            r_diff   <= alu_diff;
                            r_borrow <= alu_borrow;
                            r_dirb   <= r_rd_dir;
                            r_state  <= ST_ABS;
                        end
                        JOB_DIR: begin
                            r_job   <= JOB_SPAN_A;
                            r_fx    <= e0;
                            r_state <= ST_F0;
                            if (r_dira == r_rd_dir) begin
                                r_fy <= e1;
                                r_bx <= e2;
                                r_by <= e3;
                            end else begin
                                r_fy <= e3;
                                r_bx <= e1;
                                r_by <= e2;
                            end
                        end
                        JOB_SPAN_A: begin
                            r_a <= span_new;
                            if (r_m == POS_W'(5)) begin
                                r_job   <= JOB_SPAN_B;
                                r_fx    <= r_bx;
                                r_fy    <= r_by;
                                r_state <= ST_F0;
                            end else begin
                                r_ok     <= 1'b1;
                                r_chosen <= CHOSEN_MIN;
                                r_state  <= ST_EMIT;
                            end
                        end
                        default: begin
                            r_b      <= span_new;
                            r_ok     <= 1'b1;
                            r_chosen <= CHOSEN_MIN;
                            r_state  <= ST_EMIT;
                        end
                    endcase
                end
                ST_ABS: begin
                    if (pair_pass) begin
                        if (r_two) begin
                            r_m <= POS_W'(1);
                        end else begin
                            r_m     <= POS_W'(3);
                            r_drop1 <= (r_pc == 2'd0);
                        end
                        r_state <= ST_M0;
                    end else if (r_two) begin
                        // Two distinct profiles: the later one wins a tie here.
                        r_m      <= POS_W'(2);
                        r_tie_le <= 1'b1;
                        r_state  <= ST_M0;
                    end else if (r_pc != 2'd2) begin
                        r_pc    <= r_pc + 2'd1;
                        r_fx    <= (r_pc == 2'd0) ? IDX_W'(2) : IDX_W'(0);
                        r_fy    <= IDX_W'(3);
                        r_state <= ST_F0;
                    end else begin
                        r_ok     <= 1'b0;
                        r_chosen <= CHOSEN_MIN;
                        r_state  <= ST_EMIT;
                    end
                end
                ST_M0: begin
                    r_state <= ST_M1;
                end
                ST_M1: begin
                    r_best_core <= r_rd_core;
                    r_best      <= '0;
                    r_i         <= POS_W'(1);
                    r_state     <= (r_m == POS_W'(1)) ? ST_SMIN : ST_MLOOP;
                end
                ST_MLOOP: begin
                    r_best <= best_sel;
                    if (min_upd) begin
                        r_best_core <= r_rd_core;
                    end
                    if (min_done) begin
                        r_state <= ST_SMIN;
                    end else begin
                        r_i <= r_i + POS_W'(1);
                    end
                end
                ST_SMIN: begin
                    r_min_idx  <= map_pos(r_best, r_drop1);
                    r_min_time <= r_rd_total;
                    r_a        <= '0;
                    r_b        <= '0;
                    r_chosen   <= CHOSEN_MIN;
                    case (r_m)
                        POS_W'(1): begin
                            r_ok    <= 1'b1;
                            r_state <= ST_EMIT;
                        end
                        POS_W'(2): begin
                            r_job   <= JOB_SPAN_A;
                            r_fx    <= map_pos(r_best, r_drop1);
                            r_fy    <= e0;
                            r_state <= ST_F0;
                        end
                        POS_W'(3): begin
                            r_job   <= JOB_SPAN_A;
                            r_fx    <= e0;
                            r_fy    <= e1;
                            r_state <= ST_F0;
                        end
                        POS_W'(5): begin
                            r_job   <= JOB_DIR;
                            r_fx    <= e0;
                            r_fy    <= e1;
                            r_state <= ST_F0;
                        end
                        default: begin
                            r_ok    <= 1'b0;
                            r_state <= ST_EMIT;
                        end
                    endcase
                end
                ST_Q0: begin
                    r_ge_b  <= r_b.valid && !alu_borrow;
                    r_state <= ST_Q1;
                end
                ST_Q1: begin
                    r_ok <= 1'b1;
                    if (r_ge_b) begin
                        r_chosen <= CHOSEN_B;
                    end else if (r_a.valid && !alu_borrow) begin
                        r_chosen <= CHOSEN_A;
                    end else begin
                        r_chosen <= CHOSEN_MIN;
                    end
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (i_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_result.ok        = r_ok;
    assign o_result.min_index = r_min_idx[OUT_IDX_W-1:0];
    assign o_result.t_min     = r_min_time;
    assign o_result.a_valid   = r_a.valid;
    assign o_result.a_left    = r_a.left;
    assign o_result.a_right   = r_a.right;
    assign o_result.a_index   = r_a.idx[OUT_IDX_W-1:0];
    assign o_result.b_valid   = r_b.valid;
    assign o_result.b_left    = r_b.left;
    assign o_result.b_right   = r_b.right;
    assign o_result.b_index   = r_b.idx[OUT_IDX_W-1:0];
    assign o_result.chosen    = r_chosen;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STORE_DEPTH))
        else $error("profile count exceeds the store depth");

    a_b_needs_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b.valid |-> r_a.valid)
        else $error("interval b is valid without interval a");

    a_push_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> (r_state == ST_IDLE))
        else $error("sequencer did not return to idle after a result");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_cmd == CMD_LOAD) && i_last) |=> (r_count == '0))
        else $error("profile count not cleared after the last load");

    a_loop_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MLOOP) |-> (r_i < r_m))
        else $error("minimum search ran past the profile set");

endmodule

FILE: hw/rtl/profile_block_interval_selector.sv
// Profile block interval selector.
// Items arrive on the s_axis channel. tuser selects the command: load one
// candidate profile or query by time. tlast marks the final profile of a set.
// A load that is not last is stored while s_axis_tready stays high and gives
// no result. The last load starts the selection over the stored set, which
// walks the stored profiles through one shared 64-bit subtractor and a
// single-read-port profile store; how soon its result reaches m_axis depends
// on the set: an even count above four is quickest, a four-profile set that
// merges only at its third pair check is slowest.
// A query makes two compares before it gives its result.
// s_axis_tready is low while an item is being worked on, so one item is in
// work at a time. The result sits in an output register; if the receiver
// holds m_axis_tready low, the block still takes the next item and holds
// the following result until the register frees up.
// The three tolerance registers are written over the APB port at byte
// addresses 0, 4 and 8 and read back there; pready is always high.
// Reset clears the load count, the minimum, both intervals and the output
// valid flag, and sets all tolerances to one.
module profile_block_interval_selector (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // core_time[63:0], total_time[127:64], direction[128], query_time[192:129]
    input  logic [199:0] s_axis_tdata,
    input  logic         s_axis_tlast,
    // cmd[0]
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // ok[0], min_index[3:1], t_min[67:4], a_valid[68], a_left[132:69],
    // a_right[196:133], a_index[199:197], b_valid[200], b_left[264:201],
    // b_right[328:265], b_index[331:329], chosen[333:332]
    output logic [335:0] m_axis_tdata
);
    import pbis_pkg::*;

    localparam logic [1:0] REG_TOL_TWO   = 2'd0;
    localparam logic [1:0] REG_TOL_FIRST = 2'd1;
    localparam logic [1:0] REG_TOL_OTHER = 2'd2;

    t_tol    r_tol;
    logic    r_out_valid;
    t_result r_out_data;
    t_result result;
    logic    out_free;
    logic    push;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol.two        <= TOL_W'(1);
            r_tol.first_pair <= TOL_W'(1);
            r_tol.other_pair <= TOL_W'(1);
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                REG_TOL_TWO:   r_tol.two        <= pwdata[TOL_W-1:0];
                REG_TOL_FIRST: r_tol.first_pair <= pwdata[TOL_W-1:0];
                REG_TOL_OTHER: r_tol.other_pair <= pwdata[TOL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_TOL_TWO:   prdata = {16'b0, r_tol.two};
            REG_TOL_FIRST: prdata = {16'b0, r_tol.first_pair};
            REG_TOL_OTHER: prdata = {16'b0, r_tol.other_pair};
            default:       prdata = '0;
        endcase
    end

    assign out_free = !r_out_valid || m_axis_tready;

    pbis_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_cmd        (s_axis_tuser[0]),
        .i_core_time  (s_axis_tdata[63:0]),
        .i_total_time (s_axis_tdata[127:64]),
        .i_direction  (s_axis_tdata[128]),
        .i_last       (s_axis_tlast),
        .i_query_time (s_axis_tdata[192:129]),
        .i_tol        (r_tol),
        .i_out_free   (out_free),
        .o_push       (push),
        .o_result     (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push) begin
            r_out_valid <= 1'b1;
            r_out_data  <= result;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b0, r_out_data};

endmodule

FILE: dv/tb.sv
module tb;

    import pbis_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned SETTLE_CYCLES  = 40;
    localparam int unsigned PHASE_ITEMS    = 270;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } t_cmd;

    typedef enum int {
        REG_TOL_TWO        = 0,
        REG_TOL_FIRST_PAIR = 1,
        REG_TOL_OTHER_PAIR = 2
    } t_tol_reg;

    typedef struct {
        t_cmd              cmd;
        logic [TIME_W-1:0] core;
        logic [TIME_W-1:0] total;
        logic              dir;
        logic              last;
        logic [TIME_W-1:0] qtime;
    } t_profile_item;

    typedef struct packed {
        logic                 valid;
        logic [TIME_W-1:0]    left;
        logic [TIME_W-1:0]    right;
        logic [OUT_IDX_W-1:0] idx;
    } t_span;

    class interval_scoreboard;
        logic [TIME_W-1:0]    core_mem [STORE_DEPTH];
        logic [TIME_W-1:0]    total_mem[STORE_DEPTH];
        logic                 dir_mem  [STORE_DEPTH];
        int unsigned          n_stored  = 0;
        logic [OUT_IDX_W-1:0] min_idx   = '0;
        logic [TIME_W-1:0]    min_total = '0;
        t_span                span_a    = '0;
        t_span                span_b    = '0;
        logic [TOL_W-1:0]     tol_two   = 1;
        logic [TOL_W-1:0]     tol_first = 1;
        logic [TOL_W-1:0]     tol_other = 1;
        t_result              pending_q[$];
        int unsigned          n_loads   = 0;
        int unsigned          n_queries = 0;
        int unsigned          n_sets    = 0;
        int unsigned          n_checked = 0;
        int unsigned          n_errors  = 0;

        function void set_tol(t_tol_reg r, logic [TOL_W-1:0] v);
            case (r)
                REG_TOL_TWO:        tol_two   = v;
                REG_TOL_FIRST_PAIR: tol_first = v;
                default:            tol_other = v;
            endcase
        endfunction

        function logic [TIME_W-1:0] core_gap(int x, int y);
            return (core_mem[x] > core_mem[y]) ? core_mem[x] - core_mem[y]
                                               : core_mem[y] - core_mem[x];
        endfunction

        function void take_min(int i);
            min_idx   = i[OUT_IDX_W-1:0];
            min_total = total_mem[i];
            span_a    = '0;
            span_b    = '0;
        endfunction

        // The wider total owns the span; on equal totals the first of the pair does.
        function t_span build_span(int l, int r);
            t_span s;
            s.valid = 1'b1;
            if (total_mem[l] < total_mem[r]) begin
                s.left  = total_mem[l];
                s.right = total_mem[r];
                s.idx   = r[OUT_IDX_W-1:0];
            end else begin
                s.left  = total_mem[r];
                s.right = total_mem[l];
                s.idx   = l[OUT_IDX_W-1:0];
            end
            return s;
        endfunction

        function bit select_blocks(int n);
            int map[STORE_DEPTH];
            int e[4];
            int m, best, j, drop;
            for (int i = 0; i < n; i++) map[i] = i;
            m = n;
            j = 0;
            if (n == 1) begin
                take_min(0);
                return 1'b1;
            end
            if (n == 2) begin
                if (core_gap(0, 1) < 64'(tol_two)) begin
                    take_min(0);
                    return 1'b1;
                end
                best = (core_mem[0] < core_mem[1]) ? 0 : 1;
                take_min(best);
                span_a = build_span(best, best ^ 1);
                return 1'b1;
            end
            if (n == 4) begin
                // A near-equal pair running in opposite directions collapses to one.
                if (core_gap(0, 1) < 64'(tol_first) && dir_mem[0] != dir_mem[1])
                    drop = 1;
                else if (core_gap(2, 3) < 64'(tol_other) && dir_mem[2] != dir_mem[3])
                    drop = 3;
                else if (core_gap(0, 3) < 64'(tol_other) && dir_mem[0] != dir_mem[3])
                    drop = 3;
                else
                    return 1'b0;
                for (int i = 0; i < 4; i++) begin
                    if (i != drop) begin
                        map[j] = i;
                        j++;
                    end
                end
                m = 3;
            end else if (n % 2 == 0) begin
                return 1'b0;
            end
            best = 0;
            for (int i = 1; i < m; i++)
                if (core_mem[map[i]] < core_mem[map[best]]) best = i;
            take_min(map[best]);
            if (m == 3) begin
                span_a = build_span(map[(best + 1) % 3], map[(best + 2) % 3]);
                return 1'b1;
            end
            if (m == 5) begin
                for (int k = 0; k < 4; k++) e[k] = map[(best + 1 + k) % 5];
                if (dir_mem[e[0]] == dir_mem[e[1]]) begin
                    span_a = build_span(e[0], e[1]);
                    span_b = build_span(e[2], e[3]);
                end else begin
                    span_a = build_span(e[0], e[3]);
                    span_b = build_span(e[1], e[2]);
                end
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function t_result form_result(bit ok, logic [CHOSEN_W-1:0] pick);
            t_result r;
            r.ok        = ok;
            r.min_index = min_idx;
            r.t_min     = min_total;
            r.a_valid   = span_a.valid;
            r.a_left    = span_a.left;
            r.a_right   = span_a.right;
            r.a_index   = span_a.idx;
            r.b_valid   = span_b.valid;
            r.b_left    = span_b.left;
            r.b_right   = span_b.right;
            r.b_index   = span_b.idx;
            r.chosen    = pick;
            return r;
        endfunction

        function void note_item(t_profile_item it);
            logic [CHOSEN_W-1:0] pick;
            bit                  ok;
            if (it.cmd == CMD_QUERY) begin
                n_queries++;
                pick = CHOSEN_MIN;
                if (span_b.valid && it.qtime >= span_b.right)
                    pick = CHOSEN_B;
                else if (span_a.valid && it.qtime >= span_a.right)
                    pick = CHOSEN_A;
                pending_q.push_back(form_result(1'b1, pick));
                return;
            end
            // Once the store is full further loads are dropped.
            if (n_stored < STORE_DEPTH) begin
                core_mem[n_stored]  = it.core;
                total_mem[n_stored] = it.total;
                dir_mem[n_stored]   = it.dir;
                n_stored++;
                n_loads++;
            end
            if (!it.last) return;
            ok = select_blocks(n_stored);
            n_stored = 0;
            n_sets++;
            pending_q.push_back(form_result(ok, CHOSEN_MIN));
        endfunction

        function void cmp_field(string name, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
            if (want !== got) begin
                n_errors++;
                if (n_errors <= 40)
                    $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 40)
                    $display("%0t: unexpected result, expected none got %0h", $time, got);
                return;
            end
            want = pending_q.pop_front();
            n_checked++;
            cmp_field("ok",        want.ok,        got.ok);
            cmp_field("min_index", want.min_index, got.min_index);
            cmp_field("t_min",     want.t_min,     got.t_min);
            cmp_field("a_valid",   want.a_valid,   got.a_valid);
            cmp_field("a_left",    want.a_left,    got.a_left);
            cmp_field("a_right",   want.a_right,   got.a_right);
            cmp_field("a_index",   want.a_index,   got.a_index);
            cmp_field("b_valid",   want.b_valid,   got.b_valid);
            cmp_field("b_left",    want.b_left,    got.b_left);
            cmp_field("b_right",   want.b_right,   got.b_right);
            cmp_field("b_index",   want.b_index,   got.b_index);
            cmp_field("chosen",    want.chosen,    got.chosen);
        endfunction
    endclass

    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         psel          = 1'b0;
    logic         penable       = 1'b0;
    logic         pwrite        = 1'b0;
    logic [3:0]   paddr         = '0;
    logic [31:0]  pwdata        = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [199:0] s_axis_tdata  = '0;
    logic         s_axis_tlast  = 1'b0;
    logic [0:0]   s_axis_tuser  = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [335:0] m_axis_tdata;

    interval_scoreboard sb = new;
    int unsigned src_idle    = 0;
    int unsigned snk_stall   = 0;
    int unsigned quiet_count = 0;

    profile_block_interval_selector dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= snk_stall);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(t_result'(m_axis_tdata[$bits(t_result)-1:0]));
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable))
            quiet_count <= 0;
        else
            quiet_count <= quiet_count + 1;
        if (quiet_count >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, quiet_count, sb.pending_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic write_tol(t_tol_reg r, logic [TOL_W-1:0] v);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = 4'(int'(r) * 4);
        pwdata  = 32'(v);
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_tol(r, v);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Called and returns at a falling edge; valid stays high into the next item.
    task automatic send_item(t_cmd cmd, logic [63:0] core, logic [63:0] total,
                             logic dir, logic last, logic [63:0] qtime);
        t_profile_item it;
        it = '{cmd, core, total, dir, last, qtime};
        while ($urandom_range(0, 99) < src_idle) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tdata  = {7'd0, qtime, dir, total, core};
        s_axis_tuser  = cmd;
        s_axis_tlast  = last;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_item(it);
        @(negedge i_clk);
    endtask

    task automatic load_profile(logic [63:0] core, logic [63:0] total, logic dir, logic last);
        send_item(CMD_LOAD, core, total, dir, last, {$urandom, $urandom});
    endtask

    task automatic query_at(logic [63:0] t);
        send_item(CMD_QUERY, {$urandom, $urandom}, {$urandom, $urandom},
                  1'($urandom), 1'($urandom), t);
    endtask

    // Query times cluster on the interval edges where the answer flips.
    task automatic random_query();
        logic [63:0] t;
        case ($urandom_range(0, 8))
            0:       t = '0;
            1:       t = '1;
            2:       t = sb.span_a.right;
            3:       t = sb.span_a.right - 1;
            4:       t = sb.span_b.right;
            5:       t = sb.span_b.right - 1;
            6:       t = sb.span_b.right + 1;
            default: t = {$urandom, $urandom};
        endcase
        query_at(t);
    endtask

    function automatic logic [63:0] near_core(logic [63:0] base);
        logic [63:0]      d;
        logic [TOL_W-1:0] t;
        case ($urandom_range(0, 2))
            0:       t = sb.tol_two;
            1:       t = sb.tol_first;
            default: t = sb.tol_other;
        endcase
        case ($urandom_range(0, 4))
            0:       d = '0;
            1:       d = 64'(t) - 1;
            2:       d = 64'(t);
            3:       d = 64'(t) + 1;
            default: d = 64'($urandom_range(0, 3));
        endcase
        return $urandom_range(0, 1) ? base + d : base - d;
    endfunction

    task automatic random_set();
        int unsigned r, n;
        logic [63:0] base, tot_base, c, tt;
        r = $urandom_range(0, 99);
        if      (r < 18) n = 1;
        else if (r < 33) n = 2;
        else if (r < 50) n = 3;
        else if (r < 68) n = 4;
        else if (r < 86) n = 5;
        else if (r < 91) n = 6;
        else if (r < 95) n = 7;
        else if (r < 98) n = 8;
        else             n = $urandom_range(9, 11);
        case ($urandom_range(0, 9))
            0:       base = '0;
            1:       base = '1;
            default: base = {$urandom, $urandom};
        endcase
        tot_base = {$urandom, $urandom};
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) random_query();
            c = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : near_core(base);
            case ($urandom_range(0, 5))
                0:       tt = tot_base;
                1:       tt = '0;
                2:       tt = '1;
                default: tt = {$urandom, $urandom};
            endcase
            load_profile(c, tt, 1'($urandom), i == n - 1);
        end
        repeat ($urandom_range(0, 3)) random_query();
    endtask

    task automatic settle();
        s_axis_tvalid = 1'b0;
        while (sb.pending_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        int unsigned goal;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed sets at the reset tolerances.
        query_at('0);
        load_profile('1, '1, 1'b1, 1'b1);
        load_profile(64'd5, 64'd100, 1'b0, 1'b0);
        load_profile(64'd5, 64'd200, 1'b1, 1'b1);
        load_profile('1, '0, 1'b0, 1'b0);
        load_profile('0, '1, 1'b1, 1'b1);
        query_at('1);
        query_at(64'hFFFF_FFFF_FFFF_FFFE);
        load_profile(64'd30, 64'd300, 1'b0, 1'b0);
        load_profile(64'd10, 64'd100, 1'b1, 1'b0);
        load_profile(64'd20, 64'd300, 1'b0, 1'b1);
        load_profile(64'd7, 64'd50, 1'b0, 1'b0);
        load_profile(64'd7, 64'd60, 1'b1, 1'b0);
        load_profile(64'd3, 64'd40, 1'b0, 1'b0);
        load_profile(64'd9, 64'd70, 1'b1, 1'b1);
        // No near-equal opposite pair: the set fails and the last result stands.
        load_profile(64'd1, 64'd10, 1'b0, 1'b0);
        load_profile(64'd100, 64'd20, 1'b0, 1'b0);
        load_profile(64'd200, 64'd30, 1'b1, 1'b0);
        load_profile(64'd300, 64'd40, 1'b0, 1'b1);
        query_at(64'd60);
        load_profile(64'd50, 64'd500, 1'b0, 1'b0);
        load_profile(64'd10, 64'd100, 1'b1, 1'b0);
        load_profile(64'd40, 64'd400, 1'b0, 1'b0);
        load_profile(64'd30, 64'd300, 1'b1, 1'b0);
        load_profile(64'd20, 64'd200, 1'b1, 1'b1);
        query_at(64'd500);
        settle();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    src_idle = 0;  snk_stall = 0;
                    write_tol(REG_TOL_TWO, '0);
                    write_tol(REG_TOL_FIRST_PAIR, '0);
                    write_tol(REG_TOL_OTHER_PAIR, '0);
                end
                1: begin
                    src_idle = 83; snk_stall = 0;
                    write_tol(REG_TOL_TWO, '1);
                    write_tol(REG_TOL_FIRST_PAIR, '1);
                    write_tol(REG_TOL_OTHER_PAIR, '1);
                end
                2: begin
                    src_idle = 0;  snk_stall = 83;
                    write_tol(REG_TOL_TWO, 16'($urandom_range(0, 8)));
                    write_tol(REG_TOL_FIRST_PAIR, 16'($urandom_range(0, 8)));
                    write_tol(REG_TOL_OTHER_PAIR, 16'($urandom_range(0, 8)));
                end
                default: begin
                    src_idle = 25; snk_stall = 25;
                    write_tol(REG_TOL_TWO, 16'($urandom));
                    write_tol(REG_TOL_FIRST_PAIR, 16'($urandom));
                    write_tol(REG_TOL_OTHER_PAIR, 16'($urandom));
                end
            endcase
            goal = sb.n_loads + sb.n_queries + PHASE_ITEMS;
            while (sb.n_loads + sb.n_queries < goal) random_set();
            settle();
        end

        $display("Checked %0d results from %0d profile loads in %0d sets and %0d queries.",
                 sb.n_checked, sb.n_loads, sb.n_sets, sb.n_queries);
        $display("Tolerances went from zero to full scale under four pacing mixes; %0d errors.",
                 sb.n_errors);
        if (sb.n_errors == 0 && sb.pending_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: profile_block_interval_selector.f
hw/rtl/pbis_pkg.sv
hw/rtl/pbis_engine.sv
hw/rtl/profile_block_interval_selector.sv
dv/tb.sv
